@@ sv/hic_pkg.sv @@
`default_nettype none
package hic_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned COUNT_W    = 17;

  localparam int unsigned MAX_MATCHES_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_H_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H_LAST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd5;

  typedef struct packed {
    logic [63:0]        h_a;
    logic [63:0]        h_b;
    logic [63:0]        h_c;
    logic [63:0]        h_d;
    logic signed [31:0] h_last;
    logic [63:0]        limit_sq;
  } cfg_t;

  typedef struct packed {
    logic inlier;
    logic last;
  } verdict_t;

endpackage
`default_nettype wire

@@ sv/hic_if.sv @@
`default_nettype none
interface hic_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;
  logic signed [31:0] dst_x;
  logic signed [31:0] dst_y;
  logic               last_pair;
  modport source (output valid, src_x, src_y, dst_x, dst_y, last_pair, input ready);
  modport sink (input valid, src_x, src_y, dst_x, dst_y, last_pair, output ready);
endinterface

interface hic_result_if;
  logic        valid;
  logic        ready;
  logic        is_inlier;
  logic [16:0] inlier_count;
  logic        set_done;
  modport source (output valid, is_inlier, inlier_count, set_done, input ready);
  modport sink (input valid, is_inlier, inlier_count, set_done, output ready);
endinterface
`default_nettype wire

@@ sv/hic_front.sv @@
`default_nettype none
module hic_front #(
  parameter int unsigned FRAC_BITS = hic_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hic_pkg::cfg_t     cfg,
  hic_pair_if.sink               in_ch,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output hic_pkg::verdict_t      push_data
);

  localparam int unsigned PW = 66 - FRAC_BITS;
  localparam int unsigned SH = 33 - FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_ERR  = 4'd4;
  localparam logic [3:0] S_SQX  = 4'd5;
  localparam logic [3:0] S_SQY  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_PUSH = 4'd8;

  logic [3:0]         state;
  logic [2:0]         mstep;
  logic [5:0]         cnt;
  logic signed [31:0] sx, sy, dx, dy;
  logic               last;
  logic signed [63:0] prod;
  logic signed [64:0] acc;
  logic signed [PW-1:0] px, py, pz;
  logic [PW-1:0]      nx, ny, dmag;
  logic [PW:0]        remx, remy;
  logic [32:0]        shx, shy, qmx, qmy;
  logic               neg_x, neg_y, fail, flag;
  logic [31:0]        mx, my;
  logic [63:0]        ex2, ey2;

  logic signed [31:0] op_a, op_b;
  logic signed [64:0] row_sum;
  logic signed [PW-1:0] row_p, row_c;
  logic [PW:0]        tx, ty;
  logic signed [34:0] qxs, qys, ex, ey;
  logic [34:0]        ax, ay;
  logic [64:0]        sum;

  always_comb begin
    case (mstep)
      3'd0: begin op_a = $signed(cfg.h_a[63:32]); op_b = sx; end
      3'd1: begin op_a = $signed(cfg.h_a[31:0]);  op_b = sy; end
      3'd2: begin op_a = $signed(cfg.h_b[31:0]);  op_b = sx; end
      3'd3: begin op_a = $signed(cfg.h_c[63:32]); op_b = sy; end
      3'd4: begin op_a = $signed(cfg.h_d[63:32]); op_b = sx; end
      default: begin op_a = $signed(cfg.h_d[31:0]); op_b = sy; end
    endcase
    case (mstep)
      3'd2: row_c = PW'($signed(cfg.h_b[63:32]));
      3'd4: row_c = PW'($signed(cfg.h_c[31:0]));
      default: row_c = PW'(cfg.h_last);
    endcase
    row_sum = acc + 65'(prod);
    row_p   = PW'(row_sum >>> FRAC_BITS) + row_c;
    tx = {remx[PW-1:0], shx[32]};
    ty = {remy[PW-1:0], shy[32]};
    qxs = neg_x ? -$signed({2'b00, qmx}) : $signed({2'b00, qmx});
    qys = neg_y ? -$signed({2'b00, qmy}) : $signed({2'b00, qmy});
    ex  = 35'(dx) - qxs;
    ey  = 35'(dy) - qys;
    ax  = ex[34] ? 35'(-ex) : 35'(ex);
    ay  = ey[34] ? 35'(-ey) : 35'(ey);
    sum = {1'b0, ex2} + {1'b0, ey2};
  end

  assign in_ch.ready = (state == S_IDLE);
  assign push_valid  = (state == S_PUSH);
  assign push_data   = '{inlier: flag, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mstep <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            sx    <= in_ch.src_x;
            sy    <= in_ch.src_y;
            dx    <= in_ch.dst_x;
            dy    <= in_ch.dst_y;
            last  <= in_ch.last_pair;
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= op_a * op_b;
          mstep <= mstep + 3'd1;
          if (mstep[0]) begin
            acc <= 65'(prod);
          end
          case (mstep)
            3'd2: px <= row_p;
            3'd4: py <= row_p;
            3'd6: begin
              pz    <= row_p;
              state <= S_CHK;
            end
            default: ;
          endcase
        end
        S_CHK: begin
          nx    <= px[PW-1] ? PW'(-px) : PW'(px);
          ny    <= py[PW-1] ? PW'(-py) : PW'(py);
          dmag  <= pz[PW-1] ? PW'(-pz) : PW'(pz);
          neg_x <= px[PW-1] ^ pz[PW-1];
          neg_y <= py[PW-1] ^ pz[PW-1];
          state <= S_DIV;
          cnt   <= 6'd34;
        end
        S_DIV: begin
          if (cnt == 6'd34) begin
            fail <= (pz == '0)
                 || ((PW+SH)'(nx) >= {dmag, SH'(0)})
                 || ((PW+SH)'(ny) >= {dmag, SH'(0)});
            remx <= (PW+1)'(nx >> SH);
            remy <= (PW+1)'(ny >> SH);
            shx  <= 33'({nx, FRAC_BITS'(0)});
            shy  <= 33'({ny, FRAC_BITS'(0)});
            qmx  <= '0;
            qmy  <= '0;
          end else begin
            shx <= {shx[31:0], 1'b0};
            shy <= {shy[31:0], 1'b0};
            if (tx >= {1'b0, dmag}) begin
              remx <= tx - {1'b0, dmag};
              qmx  <= {qmx[31:0], 1'b1};
            end else begin
              remx <= tx;
              qmx  <= {qmx[31:0], 1'b0};
            end
            if (ty >= {1'b0, dmag}) begin
              remy <= ty - {1'b0, dmag};
              qmy  <= {qmy[31:0], 1'b1};
            end else begin
              remy <= ty;
              qmy  <= {qmy[31:0], 1'b0};
            end
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          mx <= ax[31:0];
          my <= ay[31:0];
          if (ax[34:32] != 3'd0 || ay[34:32] != 3'd0) begin
            fail <= 1'b1;
          end
          state <= S_SQX;
        end
        S_SQX: begin
          ex2   <= mx * mx;
          state <= S_SQY;
        end
        S_SQY: begin
          ey2   <= my * my;
          state <= S_CMP;
        end
        S_CMP: begin
          flag  <= !fail && !sum[64] && (sum[63:0] < cfg.limit_sq);
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/hic_queue.sv @@
`default_nettype none
module hic_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire hic_pkg::verdict_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output hic_pkg::verdict_t      pop_data
);

  hic_pkg::verdict_t slot0, slot1;
  logic [1:0]        fill;
  logic              push, pop;
  logic              to_head;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slot0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign to_head    = (fill == 2'd0) || (fill == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill + 2'(push) - 2'(pop);
      if (push && to_head) begin
        slot0 <= push_data;
      end else if (pop) begin
        slot0 <= slot1;
      end
      if (push && !to_head) begin
        slot1 <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/hic_back.sv @@
`default_nettype none
module hic_back #(
  parameter int unsigned MAX_MATCHES = hic_pkg::MAX_MATCHES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire hic_pkg::verdict_t pop_data,
  hic_result_if.source           out_ch
);

  localparam int unsigned TW = $clog2(MAX_MATCHES + 1);

  logic [TW-1:0] tally, tally_next;
  logic          pop;

  assign pop_ready = !out_ch.valid || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    tally_next = tally;
    if (pop_data.inlier && (tally < TW'(MAX_MATCHES))) begin
      tally_next = tally + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (pop) begin
        out_ch.valid        <= 1'b1;
        out_ch.is_inlier    <= pop_data.inlier;
        out_ch.set_done     <= pop_data.last;
        out_ch.inlier_count <= hic_pkg::COUNT_W'(tally_next);
        tally               <= pop_data.last ? '0 : tally_next;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  a_tally_bound: assert property (@(posedge clk) disable iff (rst)
    tally <= TW'(MAX_MATCHES)) else $error("tally above limit");

  a_set_clears: assert property (@(posedge clk) disable iff (rst)
    pop && pop_data.last |=> tally == '0) else $error("tally not cleared after set");

  a_outlier_holds: assert property (@(posedge clk) disable iff (rst)
    pop && !pop_data.inlier && !pop_data.last |=> $stable(tally))
    else $error("tally moved on outlier");

endmodule
`default_nettype wire

@@ sv/homography_inlier_counter.sv @@
`default_nettype none
// Homography reprojection inlier counter.
// in_ch carries one matched pair a word (src_x, src_y, dst_x, dst_y, last_pair,
// signed fixed point with FRAC_BITS fraction bits); out_ch returns one word per
// pair: is_inlier, the running inlier_count of the set and set_done.
// The user is to write registers through cfg_we / cfg_index / cfg_data only
// while idle; the block itself does not enforce this. Each pair passes
// through the front end in order: the shared 32x32 multiplier for the three
// projected rows, a check state, the bit-serial restoring divider (one
// quotient bit a cycle, x and y side by side), an error state, squaring of the
// x and y errors, a compare and a hand-over state that waits for queue space.
// in_ch.ready is high only when idle, so a new pair is taken only once the
// front end is through with the last one. A two-word queue sits between
// front and back; the back end counts and holds the result in an output
// register, so a stalled receiver blocks the front only once the queue is
// full. Reset empties the queue, clears the count and loads identity h22.
module homography_inlier_counter #(
  parameter int unsigned MAX_MATCHES = hic_pkg::MAX_MATCHES_DEF,
  parameter int unsigned FRAC_BITS   = hic_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hic_pkg::CFG_DATA_W-1:0]  cfg_data,
  hic_pair_if.sink                             in_ch,
  hic_result_if.source                         out_ch
);

  hic_pkg::cfg_t     cfg;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  hic_pkg::verdict_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.h_a      <= '0;
      cfg.h_b      <= '0;
      cfg.h_c      <= '0;
      cfg.h_d      <= '0;
      cfg.h_last   <= $signed(32'(1) << FRAC_BITS);
      cfg.limit_sq <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hic_pkg::REG_H_A:    cfg.h_a      <= cfg_data;
        hic_pkg::REG_H_B:    cfg.h_b      <= cfg_data;
        hic_pkg::REG_H_C:    cfg.h_c      <= cfg_data;
        hic_pkg::REG_H_D:    cfg.h_d      <= cfg_data;
        hic_pkg::REG_H_LAST: cfg.h_last   <= $signed(cfg_data[31:0]);
        hic_pkg::REG_LIMIT:  cfg.limit_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  hic_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  hic_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  hic_back #(.MAX_MATCHES(MAX_MATCHES)) u_back (
    .clk(clk), .rst(rst),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_ch(out_ch)
  );

endmodule
`default_nettype wire
